// File: design/msp_pkg.sv
// shared types, constants and saturating arithmetic for the speed estimate and pi loop
package msp_pkg;

    // angle wrap constants in q3.13
    localparam int ANGLE_HALF_TURN = 25736;
    localparam int ANGLE_FULL_TURN = 51472;

    // widths
    localparam int ANGLE_W = 16;
    localparam int DIFF_W  = 18;
    localparam int WORD_W  = 32;
    localparam int OPND_W  = 33;
    localparam int PROD_W  = 64;
    localparam int RATE_W  = 16;
    localparam int PP_W    = 7;
    localparam int INDEX_W = 8;
    localparam int FRAC_W  = 16;
    localparam int RAW_SHIFT = 3;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [PROD_W-1:0] WIDE_MAX = 64'sd2147483647;
    localparam logic signed [PROD_W-1:0] WIDE_MIN = -64'sd2147483648;

    // register indexes
    typedef enum logic [INDEX_W-1:0] {
        REG_SAMPLE_RATE      = 8'd0,
        REG_FILTER_A         = 8'd1,
        REG_FILTER_B         = 8'd2,
        REG_POLE_PAIRS       = 8'd3,
        REG_INTEGRAL_GAIN    = 8'd4,
        REG_REFERENCE_WEIGHT = 8'd5,
        REG_LOOP_GAIN        = 8'd6,
        REG_INERTIA          = 8'd7
    } reg_index_t;

    // configuration contents
    typedef struct packed {
        logic        [RATE_W-1:0] sample_rate;
        logic signed [WORD_W-1:0] filter_a;
        logic signed [WORD_W-1:0] filter_b;
        logic        [PP_W-1:0]   pole_pairs;
        logic signed [WORD_W-1:0] integral_gain;
        logic signed [WORD_W-1:0] reference_weight;
        logic signed [WORD_W-1:0] loop_gain;
        logic signed [WORD_W-1:0] inertia;
    } cfg_t;

    // operand pair for the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_RAW,
        MUL_FA,
        MUL_FB_RAW,
        MUL_FB_DIFF,
        MUL_PP,
        MUL_KI,
        MUL_ALFA,
        MUL_KV,
        MUL_J
    } mul_op_t;

    // post-processing of the product and adder work
    typedef enum logic [3:0] {
        ALU_NOP,
        ALU_RAW,
        ALU_ACC_MUL,
        ALU_ACC_ADD,
        ALU_FILT_DIFF,
        ALU_FILT_DONE,
        ALU_ERR,
        ALU_ELEC,
        ALU_INTEG,
        ALU_CMD_ADD,
        ALU_CMD_SUB,
        ALU_CMD_Q
    } alu_op_t;

    // controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_RAW,
        ST_MUL_FA,
        ST_MUL_FB_RAW,
        ST_ADD1,
        ST_SUB1,
        ST_MUL_FB_DIFF,
        ST_ADD2,
        ST_MUL_PP,
        ST_MUL_KI,
        ST_MUL_ALFA,
        ST_CMD_ADD,
        ST_CMD_SUB,
        ST_MUL_KV,
        ST_CMD_Q,
        ST_MUL_J,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    load_in;
        mul_op_t mul_op;
        alu_op_t alu_op;
        logic    load_out;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } dp_status_t;

    // clamp a wide signed value to 32 bits
    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        if (v > WIDE_MAX) begin
            return WORD_MAX;
        end else if (v < WIDE_MIN) begin
            return WORD_MIN;
        end
        return $signed(v[WORD_W-1:0]);
    endfunction

    // saturating add
    function automatic logic signed [WORD_W-1:0] add_sat(input logic signed [WORD_W-1:0] a,
                                                         input logic signed [WORD_W-1:0] b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1]) begin
            return s[WORD_W] ? WORD_MIN : WORD_MAX;
        end
        return $signed(s[WORD_W-1:0]);
    endfunction

    // saturating subtract
    function automatic logic signed [WORD_W-1:0] sub_sat(input logic signed [WORD_W-1:0] a,
                                                         input logic signed [WORD_W-1:0] b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1]) begin
            return s[WORD_W] ? WORD_MIN : WORD_MAX;
        end
        return $signed(s[WORD_W-1:0]);
    endfunction

    // q16.16 product: floor shift then clamp
    function automatic logic signed [WORD_W-1:0] qmul_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] q;
        q = p >>> FRAC_W;
        return sat32(q);
    endfunction

endpackage

// File: design/msp_cfg_regs.sv
// configuration register file for the speed estimate and pi loop
module msp_cfg_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [msp_pkg::INDEX_W-1:0] cfg_index,
    input  logic [msp_pkg::WORD_W-1:0]  cfg_data,
    output msp_pkg::cfg_t              cfg
);
    import msp_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register writes, unknown indexes dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_rate      <= RATE_W'(10000);
            cfg_reg.filter_a         <= '0;
            cfg_reg.filter_b         <= '0;
            cfg_reg.pole_pairs       <= PP_W'(1);
            cfg_reg.integral_gain    <= '0;
            cfg_reg.reference_weight <= '0;
            cfg_reg.loop_gain        <= '0;
            cfg_reg.inertia          <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SAMPLE_RATE:      cfg_reg.sample_rate      <= cfg_data[RATE_W-1:0];
                REG_FILTER_A:         cfg_reg.filter_a         <= $signed(cfg_data);
                REG_FILTER_B:         cfg_reg.filter_b         <= $signed(cfg_data);
                REG_POLE_PAIRS:       cfg_reg.pole_pairs       <= cfg_data[PP_W-1:0];
                REG_INTEGRAL_GAIN:    cfg_reg.integral_gain    <= $signed(cfg_data);
                REG_REFERENCE_WEIGHT: cfg_reg.reference_weight <= $signed(cfg_data);
                REG_LOOP_GAIN:        cfg_reg.loop_gain        <= $signed(cfg_data);
                REG_INERTIA:          cfg_reg.inertia          <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

endmodule

// File: design/msp_ctrl.sv
// sequencing state machine for the speed estimate and pi loop
module msp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  msp_pkg::dp_status_t stat,
    output msp_pkg::ctrl_cmd_t  cmd
);
    import msp_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb begin
        state_next   = state_reg;
        cmd.load_in  = 1'b0;
        cmd.mul_op   = MUL_NONE;
        cmd.alu_op   = ALU_NOP;
        cmd.load_out = 1'b0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
                if (s_valid) state_next = ST_MUL_RAW;
            end
            ST_MUL_RAW: begin
                cmd.mul_op = MUL_RAW;
                state_next = ST_MUL_FA;
            end
            ST_MUL_FA: begin
                cmd.alu_op = ALU_RAW;
                cmd.mul_op = MUL_FA;
                state_next = ST_MUL_FB_RAW;
            end
            ST_MUL_FB_RAW: begin
                cmd.alu_op = ALU_ACC_MUL;
                cmd.mul_op = MUL_FB_RAW;
                state_next = ST_ADD1;
            end
            ST_ADD1: begin
                cmd.alu_op = ALU_ACC_ADD;
                state_next = ST_SUB1;
            end
            ST_SUB1: begin
                cmd.alu_op = ALU_FILT_DIFF;
                state_next = ST_MUL_FB_DIFF;
            end
            ST_MUL_FB_DIFF: begin
                cmd.mul_op = MUL_FB_DIFF;
                state_next = ST_ADD2;
            end
            ST_ADD2: begin
                cmd.alu_op = ALU_FILT_DONE;
                state_next = ST_MUL_PP;
            end
            ST_MUL_PP: begin
                cmd.alu_op = ALU_ERR;
                cmd.mul_op = MUL_PP;
                state_next = ST_MUL_KI;
            end
            ST_MUL_KI: begin
                cmd.alu_op = ALU_ELEC;
                cmd.mul_op = MUL_KI;
                state_next = ST_MUL_ALFA;
            end
            ST_MUL_ALFA: begin
                cmd.alu_op = ALU_INTEG;
                cmd.mul_op = MUL_ALFA;
                state_next = ST_CMD_ADD;
            end
            ST_CMD_ADD: begin
                cmd.alu_op = ALU_CMD_ADD;
                state_next = ST_CMD_SUB;
            end
            ST_CMD_SUB: begin
                cmd.alu_op = ALU_CMD_SUB;
                state_next = ST_MUL_KV;
            end
            ST_MUL_KV: begin
                cmd.mul_op = MUL_KV;
                state_next = ST_CMD_Q;
            end
            ST_CMD_Q: begin
                cmd.alu_op = ALU_CMD_Q;
                state_next = ST_MUL_J;
            end
            ST_MUL_J: begin
                cmd.mul_op = MUL_J;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTH
    // an accepted beat starts the sequence
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_MUL_RAW))
        else $error("accepted beat did not start the sequence");

    // finishing a result returns to idle
    a_out_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> (state_reg == ST_IDLE && s_ready))
        else $error("controller did not return to idle after result");
`endif

endmodule

// File: design/msp_datapath.sv
// datapath: angle difference, shared multiplier, saturating adder, state and output registers
module msp_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  msp_pkg::cfg_t                     cfg,
    input  msp_pkg::ctrl_cmd_t                cmd,
    output msp_pkg::dp_status_t               stat,
    input  logic signed [msp_pkg::ANGLE_W-1:0] s_angle,
    input  logic signed [msp_pkg::WORD_W-1:0]  s_speed_reference,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [msp_pkg::WORD_W-1:0]  m_filtered_speed,
    output logic signed [msp_pkg::WORD_W-1:0]  m_electrical_speed,
    output logic signed [msp_pkg::WORD_W-1:0]  m_speed_command,
    output logic signed [msp_pkg::WORD_W-1:0]  m_torque_command
);
    import msp_pkg::*;

    localparam logic signed [DIFF_W-1:0] HALF = DIFF_W'(ANGLE_HALF_TURN);
    localparam logic signed [DIFF_W-1:0] FULL = DIFF_W'(ANGLE_FULL_TURN);

    // carried state
    logic signed [ANGLE_W-1:0] last_angle_reg;
    logic signed [WORD_W-1:0]  last_raw_reg;
    logic signed [WORD_W-1:0]  filt_acc_reg;
    logic signed [WORD_W-1:0]  integ_reg;

    // working registers
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [WORD_W-1:0]  ref_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [WORD_W-1:0]  raw_reg;
    logic signed [WORD_W-1:0]  acc_reg;
    logic signed [WORD_W-1:0]  tmp_reg;
    logic signed [WORD_W-1:0]  elec_reg;
    logic signed [WORD_W-1:0]  cmd_reg;

    // output register
    logic                      out_valid_reg;
    logic signed [WORD_W-1:0]  out_filt_reg;
    logic signed [WORD_W-1:0]  out_elec_reg;
    logic signed [WORD_W-1:0]  out_cmd_reg;
    logic signed [WORD_W-1:0]  out_torque_reg;

    logic signed [DIFF_W-1:0]  diff_raw;
    logic signed [DIFF_W-1:0]  diff_dn;
    logic signed [DIFF_W-1:0]  diff_next;
    logic signed [OPND_W-1:0]  mul_a;
    logic signed [OPND_W-1:0]  mul_b;
    logic signed [2*OPND_W-1:0] mul_full;
    logic signed [WORD_W-1:0]  prod_q;

    // wrapped angle difference against the previous sample
    always_comb begin
        diff_raw = DIFF_W'(s_angle) - DIFF_W'(last_angle_reg);
        diff_dn  = (diff_raw > HALF) ? diff_raw - FULL : diff_raw;
        diff_next = (diff_dn < -HALF) ? diff_dn + FULL : diff_dn;
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_op)
            MUL_NONE: ;
            MUL_RAW: begin
                mul_a = OPND_W'(diff_reg);
                mul_b = $signed({{(OPND_W-RATE_W){1'b0}}, cfg.sample_rate});
            end
            MUL_FA: begin
                mul_a = OPND_W'(cfg.filter_a);
                mul_b = OPND_W'(filt_acc_reg);
            end
            MUL_FB_RAW: begin
                mul_a = OPND_W'(cfg.filter_b);
                mul_b = OPND_W'(raw_reg);
            end
            MUL_FB_DIFF: begin
                mul_a = OPND_W'(cfg.filter_b);
                mul_b = OPND_W'(tmp_reg);
            end
            MUL_PP: begin
                mul_a = OPND_W'(filt_acc_reg);
                mul_b = $signed({{(OPND_W-PP_W){1'b0}}, cfg.pole_pairs});
            end
            MUL_KI: begin
                mul_a = OPND_W'(cfg.integral_gain);
                mul_b = OPND_W'(tmp_reg);
            end
            MUL_ALFA: begin
                mul_a = OPND_W'(cfg.reference_weight);
                mul_b = OPND_W'(ref_reg);
            end
            MUL_KV: begin
                mul_a = OPND_W'(tmp_reg);
                mul_b = OPND_W'(cfg.loop_gain);
            end
            MUL_J: begin
                mul_a = OPND_W'(cmd_reg);
                mul_b = OPND_W'(cfg.inertia);
            end
            default: ;
        endcase
    end

    assign mul_full = mul_a * mul_b;
    assign prod_q   = qmul_sat(prod_reg);

    // input capture, product register and working values
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            diff_reg <= diff_next;
            ref_reg  <= s_speed_reference;
        end
        if (cmd.mul_op != MUL_NONE) begin
            prod_reg <= mul_full[PROD_W-1:0];
        end
        case (cmd.alu_op)
            ALU_RAW:       raw_reg  <= sat32(prod_reg <<< RAW_SHIFT);
            ALU_ACC_MUL:   acc_reg  <= prod_q;
            ALU_ACC_ADD:   acc_reg  <= add_sat(acc_reg, prod_q);
            ALU_FILT_DIFF: tmp_reg  <= sub_sat(last_raw_reg, acc_reg);
            ALU_ERR:       tmp_reg  <= sub_sat(ref_reg, filt_acc_reg);
            ALU_ELEC:      elec_reg <= sat32(prod_reg);
            ALU_CMD_ADD:   tmp_reg  <= add_sat(integ_reg, prod_q);
            ALU_CMD_SUB:   tmp_reg  <= sub_sat(tmp_reg, filt_acc_reg);
            ALU_CMD_Q:     cmd_reg  <= prod_q;
            default: ;
        endcase
    end

    // carried state across samples
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_angle_reg <= '0;
            last_raw_reg   <= '0;
            filt_acc_reg   <= '0;
            integ_reg      <= '0;
        end else begin
            if (cmd.load_in) begin
                last_angle_reg <= s_angle;
            end
            if (cmd.alu_op == ALU_FILT_DONE) begin
                filt_acc_reg <= add_sat(acc_reg, prod_q);
                last_raw_reg <= raw_reg;
            end
            if (cmd.alu_op == ALU_INTEG) begin
                integ_reg <= add_sat(integ_reg, prod_q);
            end
        end
    end

    // output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_filt_reg   <= filt_acc_reg;
            out_elec_reg   <= elec_reg;
            out_cmd_reg    <= cmd_reg;
            out_torque_reg <= prod_q;
        end
    end

    assign stat.out_busy      = out_valid_reg && !m_ready;
    assign m_valid            = out_valid_reg;
    assign m_filtered_speed   = out_filt_reg;
    assign m_electrical_speed = out_elec_reg;
    assign m_speed_command    = out_cmd_reg;
    assign m_torque_command   = out_torque_reg;

`ifndef SYNTH
    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !(out_valid_reg && !m_ready))
        else $error("result loaded over a beat not yet taken");

    // a loaded result shows up as a beat
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid)
        else $error("loaded result not presented");
`endif

endmodule

// File: design/motor_speed_estimate_and_pi_loop_unit.sv
// top level of the motor speed estimate and speed pi loop
// Each accepted beat carries a rotor angle (q3.13) and a speed reference (q16.16). The unit
// differences the angle against the previous sample, wraps it into a half turn, scales it by
// the sample rate, runs the three-step low-pass filter, scales by pole pairs and runs the pi
// loop, giving filtered speed, electrical speed, speed command and torque command, all q16.16
// with products truncated toward minus infinity and every result saturated to 32 bits. One
// item is worked at a time: the nine chained products share a single 33x33 multiplier, so
// the next beat is taken only in the cycle after the item's result is loaded; the result
// sits in an output register, so a stalled result only delays the item after it.
// Configuration writes are always ready and are to be made while the unit is idle.
module motor_speed_estimate_and_pi_loop_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [msp_pkg::ANGLE_W-1:0] s_angle,
    input  logic signed [msp_pkg::WORD_W-1:0]  s_speed_reference,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [msp_pkg::WORD_W-1:0]  m_filtered_speed,
    output logic signed [msp_pkg::WORD_W-1:0]  m_electrical_speed,
    output logic signed [msp_pkg::WORD_W-1:0]  m_speed_command,
    output logic signed [msp_pkg::WORD_W-1:0]  m_torque_command,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [msp_pkg::INDEX_W-1:0]        cfg_index,
    input  logic [msp_pkg::WORD_W-1:0]         cfg_data
);
    import msp_pkg::*;

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t stat;

    // configuration registers
    msp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer
    msp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // arithmetic and state
    msp_datapath u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg),
        .cmd                (cmd),
        .stat               (stat),
        .s_angle            (s_angle),
        .s_speed_reference  (s_speed_reference),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_filtered_speed   (m_filtered_speed),
        .m_electrical_speed (m_electrical_speed),
        .m_speed_command    (m_speed_command),
        .m_torque_command   (m_torque_command)
    );

endmodule
